// ===== hw/rtl/lts_pkg.sv =====
package lts_pkg;

  // Token kinds
  localparam logic [5:0] KIND_DOT    = 6'd5;
  localparam logic [5:0] KIND_SLASH  = 6'd9;
  localparam logic [5:0] KIND_BANG   = 6'd11;
  localparam logic [5:0] KIND_EQUAL  = 6'd13;
  localparam logic [5:0] KIND_GREATER = 6'd15;
  localparam logic [5:0] KIND_LESS   = 6'd17;
  localparam logic [5:0] KIND_IDENT  = 6'd19;
  localparam logic [5:0] KIND_STRING = 6'd20;
  localparam logic [5:0] KIND_NUMBER = 6'd21;
  localparam logic [5:0] KIND_KW_BASE = 6'd22;
  localparam logic [5:0] KIND_ERROR  = 6'd38;
  localparam logic [5:0] KIND_EOF    = 6'd39;
  localparam logic [5:0] KIND_NONE   = 6'd63;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_UNEXPECT = 2'd2;

  localparam int unsigned NUM_KEYWORDS = 16;
  localparam int unsigned MAX_RESULTS  = 3;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_SLASH    = 4'd1,
    MODE_COMMENT  = 4'd2,
    MODE_OP2      = 4'd3,
    MODE_IDENT    = 4'd4,
    MODE_NUMBER   = 4'd5,
    MODE_NUMDOT   = 4'd6,
    MODE_FRACTION = 4'd7,
    MODE_STRING   = 4'd8
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic [1:0]  error_code;
    logic [7:0]  bad_byte;
    logic        last_of_run;
  } out_t;

  // Results of one source byte
  typedef struct packed {
    logic [1:0]      count;
    out_t [2:0]      item;
  } res_set_t;

  // Keyword text, right-justified string constants
  function automatic logic [47:0] kw_text(input logic [3:0] k);
    case (k)
      4'd0:    kw_text = "and";
      4'd1:    kw_text = "class";
      4'd2:    kw_text = "else";
      4'd3:    kw_text = "false";
      4'd4:    kw_text = "for";
      4'd5:    kw_text = "fun";
      4'd6:    kw_text = "if";
      4'd7:    kw_text = "nil";
      4'd8:    kw_text = "or";
      4'd9:    kw_text = "print";
      4'd10:   kw_text = "return";
      4'd11:   kw_text = "super";
      4'd12:   kw_text = "this";
      4'd13:   kw_text = "true";
      4'd14:   kw_text = "var";
      default: kw_text = "while";
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd4, 4'd5, 4'd7, 4'd14:        kw_len = 3'd3;
      4'd1, 4'd3, 4'd9, 4'd11, 4'd15:       kw_len = 3'd5;
      4'd2, 4'd12, 4'd13:                   kw_len = 3'd4;
      4'd6, 4'd8:                           kw_len = 3'd2;
      default:                              kw_len = 3'd6;
    endcase
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic ident_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

endpackage

// ===== hw/rtl/lts_scan_core.sv =====
module lts_scan_core import lts_pkg::*; #(
  parameter int unsigned COUNTER_BITS    = 32,
  parameter int unsigned KEYWORD_MAX_LEN = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_t      in_i,
  output res_set_t res_o
);

  localparam int unsigned W  = COUNTER_BITS;
  localparam int unsigned IW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [W-1:0] CMAX = {W{1'b1}};

  scan_mode_e   mode_q, mode_d;
  logic [7:0]   prefix_q [KEYWORD_MAX_LEN];
  logic [W-1:0] start_q, start_d;
  logic [W-1:0] pos_q, pos_d;
  logic [W-1:0] line_q, line_d;
  logic [W-1:0] col_q, col_d;
  logic [7:0]   held_q, held_d;

  logic          pfx_we;
  logic [IW-1:0] pfx_idx;
  logic [7:0]    pfx_byte;

  logic [7:0]   b;
  logic [W-1:0] pos, dotpos, len_v, idx_v;
  logic [5:0]   word_k;
  logic         do_idle;
  logic [1:0]   n;
  out_t [2:0]   item;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [W-1:0] span(input logic [W-1:0] from, input logic [W-1:0] to);
    return (to > from) ? to - from : '0;
  endfunction

  function automatic logic [31:0] low32(input logic [W-1:0] v);
    logic [W+31:0] ext;
    ext = {32'd0, v};
    return ext[31:0];
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c, input logic two);
    logic [5:0] base;
    base = (c == "!") ? KIND_BANG : (c == "=") ? KIND_EQUAL :
           (c == ">") ? KIND_GREATER : KIND_LESS;
    return base + {5'd0, two};
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      "(":     punct_kind = 6'd0;
      ")":     punct_kind = 6'd1;
      "{":     punct_kind = 6'd2;
      "}":     punct_kind = 6'd3;
      ",":     punct_kind = 6'd4;
      ".":     punct_kind = KIND_DOT;
      "-":     punct_kind = 6'd6;
      "+":     punct_kind = 6'd7;
      ";":     punct_kind = 6'd8;
      "*":     punct_kind = 6'd10;
      default: punct_kind = KIND_NONE;
    endcase
  endfunction

  // Keyword lookup over the stored identifier prefix
  always_comb begin
    logic [W-1:0] wlen;
    logic         hit;
    logic [47:0]  txt;
    logic [2:0]   kl;
    wlen   = span(start_q, pos_q);
    word_k = KIND_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      txt = kw_text(4'(k));
      kl  = kw_len(4'(k));
      hit = (wlen == W'(kl));
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
        if ((i < 6) && (3'(i) < kl) && (prefix_q[i] != txt[8*(int'(kl)-1-i) +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        word_k = KIND_KW_BASE + 6'(k);
      end
    end
  end

  // One byte of scanning
  always_comb begin
    b        = in_i.source_byte;
    pos      = pos_q;
    dotpos   = (pos_q != '0) ? pos_q - 1'b1 : '0;
    len_v    = span(start_q, pos_q);
    idx_v    = len_v;
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    col_d    = col_q;
    held_d   = held_q;
    pfx_we   = 1'b0;
    pfx_idx  = '0;
    pfx_byte = b;
    do_idle  = 1'b0;
    n        = 2'd0;
    item     = '0;

    if (in_i.end_of_source) begin
      case (mode_q)
        MODE_SLASH: begin
          item[n] = '{KIND_SLASH, low32(start_q), 32'd1, low32(line_d), low32(col_d),
                      ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        MODE_OP2: begin
          item[n] = '{op_kind(held_q, 1'b0), low32(start_q), 32'd1, low32(line_d),
                      low32(col_d), ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        MODE_IDENT: begin
          item[n] = '{word_k, low32(start_q), low32(len_v), low32(line_d), low32(col_d),
                      ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        MODE_NUMBER, MODE_FRACTION: begin
          item[n] = '{KIND_NUMBER, low32(start_q), low32(len_v), low32(line_d),
                      low32(col_d), ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        MODE_NUMDOT: begin
          item[n] = '{KIND_NUMBER, low32(start_q), low32(span(start_q, dotpos)),
                      low32(line_d), low32(col_d), ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
          col_d = sat_inc(col_d);
          item[n] = '{KIND_DOT, low32(dotpos), 32'd1, low32(line_d), low32(col_d),
                      ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        MODE_STRING: begin
          item[n] = '{KIND_ERROR, low32(start_q), low32(len_v), low32(line_d),
                      low32(col_d), ERR_UNTERM, 8'd0, 1'b0};
          n = n + 2'd1;
        end
        default: ;
      endcase
      item[n] = '{KIND_EOF, low32(pos), 32'd0, low32(line_d), low32(col_d),
                  ERR_NONE, 8'd0, 1'b0};
      n = n + 2'd1;
      // back to reset values for the next source
      mode_d  = MODE_IDLE;
      start_d = '0;
      pos_d   = '0;
      line_d  = W'(1);
      col_d   = W'(1);
      held_d  = '0;
    end else begin
      case (mode_q)
        MODE_SLASH: begin
          if (b == "/") begin
            col_d  = sat_inc(col_d);
            mode_d = MODE_COMMENT;
          end else begin
            item[n] = '{KIND_SLASH, low32(start_q), 32'd1, low32(line_d), low32(col_d),
                        ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == 8'h0A) begin
            line_d = sat_inc(line_d);
            col_d  = W'(1);
            mode_d = MODE_IDLE;
          end else begin
            col_d = sat_inc(col_d);
          end
        end
        MODE_OP2: begin
          if (b == "=") begin
            col_d = sat_inc(col_d);
            item[n] = '{op_kind(held_q, 1'b1), low32(start_q), 32'd2, low32(line_d),
                        low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            item[n] = '{op_kind(held_q, 1'b0), low32(start_q), 32'd1, low32(line_d),
                        low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (ident_letter(b) || dec_digit(b)) begin
            if (idx_v < W'(KEYWORD_MAX_LEN)) begin
              pfx_we  = 1'b1;
              pfx_idx = idx_v[IW-1:0];
            end
            col_d = sat_inc(col_d);
          end else begin
            item[n] = '{word_k, low32(start_q), low32(len_v), low32(line_d), low32(col_d),
                        ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (dec_digit(b)) begin
            col_d = sat_inc(col_d);
          end else if (b == ".") begin
            mode_d = MODE_NUMDOT;
          end else begin
            item[n] = '{KIND_NUMBER, low32(start_q), low32(len_v), low32(line_d),
                        low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_NUMDOT: begin
          if (dec_digit(b)) begin
            col_d  = sat_inc(sat_inc(col_d));
            mode_d = MODE_FRACTION;
          end else begin
            item[n] = '{KIND_NUMBER, low32(start_q), low32(span(start_q, dotpos)),
                        low32(line_d), low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            col_d = sat_inc(col_d);
            item[n] = '{KIND_DOT, low32(dotpos), 32'd1, low32(line_d), low32(col_d),
                        ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_FRACTION: begin
          if (dec_digit(b)) begin
            col_d = sat_inc(col_d);
          end else begin
            item[n] = '{KIND_NUMBER, low32(start_q), low32(len_v), low32(line_d),
                        low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (b == 8'h0A) begin
            line_d = sat_inc(line_d);
            col_d  = W'(1);
          end else begin
            col_d = sat_inc(col_d);
          end
          if (b == "\"") begin
            item[n] = '{KIND_STRING, low32(start_q), low32(len_v), low32(line_d),
                        low32(col_d), ERR_NONE, 8'd0, 1'b0};
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Byte seen between tokens
      if (do_idle) begin
        start_d = pos;
        if (b == 8'h0A) begin
          line_d = sat_inc(line_d);
          col_d  = W'(1);
        end else begin
          col_d = sat_inc(col_d);
        end
        mode_d = MODE_IDLE;
        if ((b == " ") || (b == 8'h0D) || (b == 8'h0A) || (b == 8'h09)) begin
          mode_d = MODE_IDLE;
        end else if (b == "/") begin
          mode_d = MODE_SLASH;
        end else if (ident_letter(b)) begin
          pfx_we  = 1'b1;
          pfx_idx = '0;
          mode_d  = MODE_IDENT;
        end else if (dec_digit(b)) begin
          mode_d = MODE_NUMBER;
        end else if (punct_kind(b) != KIND_NONE) begin
          item[n] = '{punct_kind(b), low32(pos), 32'd1, low32(line_d), low32(col_d),
                      ERR_NONE, 8'd0, 1'b0};
          n = n + 2'd1;
        end else if ((b == "!") || (b == "=") || (b == "<") || (b == ">")) begin
          held_d = b;
          mode_d = MODE_OP2;
        end else if (b == "\"") begin
          mode_d = MODE_STRING;
        end else begin
          item[n] = '{KIND_ERROR, low32(pos), 32'd1, low32(line_d), low32(col_d),
                      ERR_UNEXPECT, b, 1'b0};
          n = n + 2'd1;
        end
      end
      pos_d = sat_inc(pos);
    end

    if (n != 2'd0) begin
      item[n - 2'd1].last_of_run = 1'b1;
    end
    res_o.count = n;
    res_o.item  = item;
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= W'(1);
      col_q   <= W'(1);
      held_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      col_q   <= col_d;
      held_q  <= held_d;
    end
  end

  // Identifier prefix, no reset
  always_ff @(posedge clk_i) begin
    if (step_i && pfx_we) begin
      prefix_q[pfx_idx] <= pfx_byte;
    end
  end

endmodule

// ===== hw/rtl/lts_result_fifo.sv =====
module lts_result_fifo import lts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  res_set_t push_data_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_t     out_data_o
);

  localparam int unsigned DEPTH = 4;

  out_t       mem_q [DEPTH];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] push_n;

  // Room for a full set of results
  assign room_o      = (cnt_q <= 3'(DEPTH - MAX_RESULTS));
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = push_i ? push_data_i.count : 2'd0;

  always_comb begin
    wr_d  = wr_q + push_n;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_n} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Up to three entries written per transfer
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        mem_q[wr_q + 2'(k)] <= push_data_i.item[k];
      end
    end
  end

endmodule

// ===== hw/rtl/lox_token_scanner.sv =====
// Lox token scanner: one source byte per transfer, up to three tokens out.
// Path: a byte waits in the input register; its tokens leave from the result FIFO.
// Throughput: one byte per cycle while each byte yields at most one token and the output is ready;
// a byte yielding two or three tokens holds the input back until the result FIFO has room again.
// Reset: asynchronous, active low; line and column return to 1, all else idle.
module lox_token_scanner import lts_pkg::*; #(
  parameter int unsigned COUNTER_BITS    = 32,
  parameter int unsigned KEYWORD_MAX_LEN = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic     in_vld_q;
  in_t      in_q;
  logic     room;
  logic     step;
  res_set_t res;

  // Input register advances when the result queue has room
  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  lts_scan_core #(
    .COUNTER_BITS   (COUNTER_BITS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .in_i  (in_q),
    .res_o (res)
  );

  lts_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step),
    .push_data_i(res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
